// ===== rtl/dled_pkg.sv =====
// Shared constants, types and command/status structs for the DLE/STX/ETX deframer.
`timescale 1ns / 1ps

package dled_pkg;

  localparam int MAX_FRAME_DEF = 32;

  localparam logic [7:0] SYM_DLE  = 8'h10;
  localparam logic [7:0] SYM_STX  = 8'h02;
  localparam logic [7:0] SYM_ETX  = 8'h03;
  localparam logic [7:0] ODD_MASK = 8'h4A;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  localparam logic [1:0] EV_DATA     = 2'd0;
  localparam logic [1:0] EV_EMPTY    = 2'd1;
  localparam logic [1:0] EV_MISMATCH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STX,
    ST_BODY,
    ST_ESC,
    ST_SUM,
    ST_EMIT
  } dled_state_t;

  typedef struct packed {
    logic       clr_frame;
    logic       store;
    logic       err_bump;
    logic       good_bump;
    logic       load_single;
    logic [1:0] single_ev;
    logic       start_emit;
    logic       emit_step;
  } dled_cmd_t;

  typedef struct packed {
    logic is_dle;
    logic is_stx;
    logic is_etx;
    logic full;
    logic sum_ok;
    logic len_zero;
    logic emit_last;
    logic out_free;
  } dled_sts_t;

endpackage

// ===== rtl/dled_ctrl.sv =====
// Frame parser and emission state machine for the DLE/STX/ETX deframer.
`timescale 1ns / 1ps

module dled_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  dled_pkg::dled_sts_t sts,
  output dled_pkg::dled_cmd_t cmd
);

  dled_pkg::dled_state_t state;
  dled_pkg::dled_state_t state_next;
  logic                  accept;

  assign in_stall = (state == dled_pkg::ST_EMIT) || !sts.out_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dled_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dled_pkg::ST_STX: begin
        if (accept) begin
          state_next = sts.is_stx ? dled_pkg::ST_BODY : dled_pkg::ST_IDLE;
        end
      end
      dled_pkg::ST_BODY: begin
        if (accept) begin
          if (sts.is_dle) begin
            state_next = dled_pkg::ST_ESC;
          end else if (sts.full) begin
            state_next = dled_pkg::ST_IDLE;
          end
        end
      end
      dled_pkg::ST_ESC: begin
        if (accept) begin
          if (sts.is_dle) begin
            state_next = sts.full ? dled_pkg::ST_IDLE : dled_pkg::ST_BODY;
          end else if (sts.is_etx) begin
            state_next = dled_pkg::ST_SUM;
          end else if (sts.is_stx) begin
            state_next = dled_pkg::ST_BODY;
          end else begin
            state_next = dled_pkg::ST_IDLE;
          end
        end
      end
      dled_pkg::ST_SUM: begin
        if (accept) begin
          if (sts.sum_ok && !sts.len_zero) begin
            state_next = dled_pkg::ST_EMIT;
          end else begin
            state_next = dled_pkg::ST_IDLE;
          end
        end
      end
      dled_pkg::ST_EMIT: begin
        if (sts.out_free && sts.emit_last) begin
          state_next = dled_pkg::ST_IDLE;
        end
      end
      default: begin
        if (accept) begin
          state_next = sts.is_dle ? dled_pkg::ST_STX : dled_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      dled_pkg::ST_STX: begin
        if (accept) begin
          cmd.clr_frame = sts.is_stx;
          cmd.err_bump  = !sts.is_stx;
        end
      end
      dled_pkg::ST_BODY: begin
        if (accept && !sts.is_dle) begin
          cmd.store    = !sts.full;
          cmd.err_bump = sts.full;
        end
      end
      dled_pkg::ST_ESC: begin
        if (accept) begin
          if (sts.is_dle) begin
            cmd.store    = !sts.full;
            cmd.err_bump = sts.full;
          end else if (sts.is_stx) begin
            cmd.clr_frame = 1'b1;
          end else if (!sts.is_etx) begin
            cmd.err_bump = 1'b1;
          end
        end
      end
      dled_pkg::ST_SUM: begin
        if (accept) begin
          if (sts.sum_ok) begin
            cmd.good_bump = 1'b1;
            if (sts.len_zero) begin
              cmd.load_single = 1'b1;
              cmd.single_ev   = dled_pkg::EV_EMPTY;
            end else begin
              cmd.start_emit = 1'b1;
            end
          end else begin
            cmd.err_bump    = 1'b1;
            cmd.load_single = 1'b1;
            cmd.single_ev   = dled_pkg::EV_MISMATCH;
          end
        end
      end
      dled_pkg::ST_EMIT: begin
        cmd.emit_step = sts.out_free;
      end
      default: begin
        if (accept) begin
          cmd.err_bump = !sts.is_dle;
        end
      end
    endcase
  end

endmodule

// ===== rtl/dled_dp.sv =====
// Payload store, checksum, counters and result register for the DLE/STX/ETX deframer.
`timescale 1ns / 1ps

module dled_dp #(
  parameter int MAX_FRAME = dled_pkg::MAX_FRAME_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          rx_byte,
  input  dled_pkg::dled_cmd_t cmd,
  output dled_pkg::dled_sts_t sts,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          event_res,
  output logic [7:0]          data_byte,
  output logic [4:0]          byte_index,
  output logic [5:0]          frame_length,
  output logic                last,
  output logic [15:0]         good_frames,
  output logic [15:0]         bad_frames
);

  localparam int CW = $clog2(MAX_FRAME + 1);
  localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;

  logic [7:0]    mem [MAX_FRAME];
  logic [CW-1:0] payload_count;
  logic [7:0]    running_xor;
  logic [AW-1:0] emit_idx;
  logic [AW-1:0] emit_idx_next;
  logic [7:0]    rd_q;
  logic [7:0]    expect_sum;
  logic [15:0]   good_count;
  logic [15:0]   error_count;

  assign expect_sum = running_xor ^ (payload_count[0] ? dled_pkg::ODD_MASK : 8'h00);

  assign sts.is_dle    = (rx_byte == dled_pkg::SYM_DLE);
  assign sts.is_stx    = (rx_byte == dled_pkg::SYM_STX);
  assign sts.is_etx    = (rx_byte == dled_pkg::SYM_ETX);
  assign sts.full      = (payload_count == CW'(MAX_FRAME));
  assign sts.sum_ok    = (rx_byte == expect_sum);
  assign sts.len_zero  = (payload_count == '0);
  assign sts.emit_last = ((CW'(emit_idx) + CW'(1)) == payload_count);
  assign sts.out_free  = !out_valid || !out_stall;

  always_comb begin
    emit_idx_next = emit_idx;
    if (cmd.start_emit) begin
      emit_idx_next = '0;
    end else if (cmd.emit_step) begin
      emit_idx_next = emit_idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[payload_count[AW-1:0]] <= rx_byte;
    end
    rd_q <= mem[emit_idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_count <= '0;
      running_xor   <= '0;
      emit_idx      <= '0;
      good_count    <= '0;
      error_count   <= '0;
      out_valid     <= 1'b0;
    end else begin
      emit_idx <= emit_idx_next;
      if (cmd.clr_frame) begin
        payload_count <= '0;
        running_xor   <= '0;
      end else if (cmd.store) begin
        payload_count <= payload_count + CW'(1);
        running_xor   <= running_xor ^ rx_byte;
      end
      if (cmd.good_bump && good_count != dled_pkg::CNT_MAX) begin
        good_count <= good_count + 16'd1;
      end
      if (cmd.err_bump && error_count != dled_pkg::CNT_MAX) begin
        error_count <= error_count + 16'd1;
      end
      if (cmd.load_single || cmd.emit_step) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      event_res    <= cmd.single_ev;
      data_byte    <= 8'h00;
      byte_index   <= 5'd0;
      frame_length <= 6'(payload_count);
      last         <= 1'b1;
    end else if (cmd.emit_step) begin
      event_res    <= dled_pkg::EV_DATA;
      data_byte    <= rd_q;
      byte_index   <= 5'(emit_idx);
      frame_length <= 6'(payload_count);
      last         <= sts.emit_last;
    end
  end

  assign good_frames = good_count;
  assign bad_frames  = error_count;

endmodule

// ===== rtl/dle_stx_etx_deframer_unit.sv =====
// Top level of the DLE/STX/ETX byte-stuffing deframer.
//
//   channel  | direction | handshake              | beat fields
//   ---------+-----------+------------------------+---------------------------------------
//   rx       | in        | in_valid / in_stall    | rx_byte
//   result   | out       | out_valid / out_stall  | event_res data_byte byte_index
//            |           |                        | frame_length last good_frames bad_frames
//
// A byte is taken whenever in_stall is low; a byte that finishes nothing gives no beat.
// The checksum byte of a good non-empty frame of N bytes gives N result beats, one per
// cycle while out_stall allows, out of the payload memory read port; in_stall stays high
// until the last beat is loaded. A stalled result register holds its beat and stalls the
// input side too. Reset does not clear the payload memory.
`timescale 1ns / 1ps

module dle_stx_etx_deframer_unit #(
  parameter int MAX_FRAME = dled_pkg::MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_res,
  output logic [7:0]  data_byte,
  output logic [4:0]  byte_index,
  output logic [5:0]  frame_length,
  output logic        last,
  output logic [15:0] good_frames,
  output logic [15:0] bad_frames
);

  dled_pkg::dled_cmd_t cmd;
  dled_pkg::dled_sts_t sts;

  dled_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dled_dp #(
    .MAX_FRAME (MAX_FRAME)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .rx_byte      (rx_byte),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .frame_length (frame_length),
    .last         (last),
    .good_frames  (good_frames),
    .bad_frames   (bad_frames)
  );

endmodule

// ===== rtl/dled_chk.sv =====
// Port-level checker for the DLE/STX/ETX deframer, bound to the top level.
`timescale 1ns / 1ps

module dled_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  event_res,
  input logic [7:0]  data_byte,
  input logic        last,
  input logic [15:0] good_frames,
  input logic [15:0] bad_frames
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(data_byte))
    else $error("result beat dropped or changed while stalled");

  a_in_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input open while result register is stalled");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != dled_pkg::EV_DATA |-> last && data_byte == 8'h00)
    else $error("empty or mismatch beat not marked last");

  a_cnt_mono: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> good_frames >= $past(good_frames) && bad_frames >= $past(bad_frames))
    else $error("frame counter decreased");

endmodule

bind dle_stx_etx_deframer_unit dled_chk u_dled_chk (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .event_res   (event_res),
  .data_byte   (data_byte),
  .last        (last),
  .good_frames (good_frames),
  .bad_frames  (bad_frames)
);
